[sv/baro_pkg.sv]
`timescale 1ns / 1ps

package baro_pkg;

	// Field widths.
	localparam int RAW_W         = 24;
	localparam int CAL_W         = 16;
	localparam int TEMP_W        = 19;
	localparam int TEMP_OUT_W    = 20;
	localparam int PRESS_W       = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int AVG_DEPTH_DEF = 20;

	// Calibration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MTEMP,
		ST_MOFF,
		ST_MSENS,
		ST_MDTSQ,
		ST_MASQ,
		ST_FIVE,
		ST_ADJ,
		ST_MPLO,
		ST_MPHI,
		ST_FULL,
		ST_DIFF,
		ST_DIV,
		ST_OUT
	} state_t;

	// Operand pair fed to the shared multiplier.
	typedef enum logic [2:0] {
		MUL_DT_C6,
		MUL_C4_DT,
		MUL_C3_DT,
		MUL_DT_DT,
		MUL_DIFF_SQ,
		MUL_D1_SLO,
		MUL_D1_SHI
	} mul_op_t;

	// Register update performed by the datapath in a cycle.
	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_TEMP,
		DP_OFF,
		DP_SENS,
		DP_T2,
		DP_A5,
		DP_ADJ,
		DP_PLO,
		DP_FULL,
		DP_DIFF,
		DP_DIV,
		DP_OUT
	} dp_step_t;

	typedef struct packed {
		mul_op_t  mul_op;
		dp_step_t step;
		logic     mean_abs;
		logic     mean_mul;
	} dp_cmd_t;

endpackage

[sv/baro_pressure_temp_compensation_core.sv]
`timescale 1ns / 1ps

// Barometric pressure and temperature compensation core.
// Input channel: one word per conversion pair (raw_temperature, raw_pressure),
// taken on a rising edge with in_valid high and in_stall low. Output channel:
// one word per input (temperature, pressure, mean temperature), taken when
// out_valid is high and out_stall is low.
// Six calibration words are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the core is idle, which the core itself
// does not enforce. Indexes beyond the sixth register are ignored. The
// arithmetic runs through one shared 26x26 multiplier, one product a cycle,
// and a new word is taken only after the core is through with the last one.
// in_stall is low only while the core is idle. A finished word waits in the
// output register; the next input word may be taken meanwhile, and its
// result is held back until the receiver has taken the previous one.
// Reset clears the calibration words, the valid bits of the temperature ring
// (AVG_DEPTH deep), its running sum and position, and the output valid flag.
module baro_pressure_temp_compensation_core #(
	parameter int AVG_DEPTH = baro_pkg::AVG_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [baro_pkg::RAW_W-1:0]             raw_temperature,
	input  logic [baro_pkg::RAW_W-1:0]             raw_pressure,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [baro_pkg::TEMP_OUT_W-1:0] temperature_centideg,
	output logic signed [baro_pkg::PRESS_W-1:0]    pressure_pa,
	output logic signed [baro_pkg::TEMP_OUT_W-1:0] avg_temperature_centideg,
	input  logic                                   cfg_we,
	input  logic [baro_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [baro_pkg::CAL_W-1:0]             cfg_data
);
	import baro_pkg::*;

	dp_cmd_t cmd;

	baro_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	baro_dp #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_dp (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.cmd                      (cmd),
		.cfg_we                   (cfg_we),
		.cfg_index                (cfg_index),
		.cfg_data                 (cfg_data),
		.raw_temperature          (raw_temperature),
		.raw_pressure             (raw_pressure),
		.temperature_centideg     (temperature_centideg),
		.pressure_pa              (pressure_pa),
		.avg_temperature_centideg (avg_temperature_centideg)
	);

	// Once a word is taken the core is busy with it.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core took a second word while busy");

	// Operands are loaded only on an input handshake.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step == DP_LOAD |-> in_valid && !in_stall)
		else $error("operands loaded without an input handshake");

	// A result load always presents a valid output word.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step == DP_OUT |=> out_valid)
		else $error("result loaded but not presented");

	// A new result appears only at the end of a busy period.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

endmodule

[sv/baro_ctrl.sv]
`timescale 1ns / 1ps

module baro_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output baro_pkg::dp_cmd_t cmd
);
	import baro_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_OUT) && out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_next = ST_MTEMP;
			ST_MTEMP: state_next = ST_MOFF;
			ST_MOFF:  state_next = ST_MSENS;
			ST_MSENS: state_next = ST_MDTSQ;
			ST_MDTSQ: state_next = ST_MASQ;
			ST_MASQ:  state_next = ST_FIVE;
			ST_FIVE:  state_next = ST_ADJ;
			ST_ADJ:   state_next = ST_MPLO;
			ST_MPLO:  state_next = ST_MPHI;
			ST_MPHI:  state_next = ST_FULL;
			ST_FULL:  state_next = ST_DIFF;
			ST_DIFF:  state_next = ST_DIV;
			ST_DIV:   state_next = ST_OUT;
			ST_OUT:   if (out_free) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	// Each multiply is registered; the following state consumes the product.
	always_comb begin
		cmd      = '{mul_op: MUL_DT_C6, step: DP_NONE, mean_abs: 1'b0, mean_mul: 1'b0};
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd.step = DP_LOAD;
			end
			ST_MTEMP: cmd.mul_op = MUL_DT_C6;
			ST_MOFF: begin
				cmd.mul_op = MUL_C4_DT;
				cmd.step   = DP_TEMP;
			end
			ST_MSENS: begin
				cmd.mul_op = MUL_C3_DT;
				cmd.step   = DP_OFF;
			end
			ST_MDTSQ: begin
				cmd.mul_op = MUL_DT_DT;
				cmd.step   = DP_SENS;
			end
			ST_MASQ: begin
				cmd.mul_op = MUL_DIFF_SQ;
				cmd.step   = DP_T2;
			end
			ST_FIVE: cmd.step = DP_A5;
			ST_ADJ:  cmd.step = DP_ADJ;
			ST_MPLO: begin
				cmd.mul_op   = MUL_D1_SLO;
				cmd.mean_abs = 1'b1;
			end
			ST_MPHI: begin
				cmd.mul_op   = MUL_D1_SHI;
				cmd.step     = DP_PLO;
				cmd.mean_mul = 1'b1;
			end
			ST_FULL: cmd.step = DP_FULL;
			ST_DIFF: cmd.step = DP_DIFF;
			ST_DIV:  cmd.step = DP_DIV;
			ST_OUT:  if (out_free) cmd.step = DP_OUT;
			default: cmd.step = DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/baro_dp.sv]
`timescale 1ns / 1ps

module baro_dp #(
	parameter int AVG_DEPTH = baro_pkg::AVG_DEPTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  baro_pkg::dp_cmd_t                       cmd,
	input  logic                                    cfg_we,
	input  logic [baro_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [baro_pkg::CAL_W-1:0]              cfg_data,
	input  logic [baro_pkg::RAW_W-1:0]              raw_temperature,
	input  logic [baro_pkg::RAW_W-1:0]              raw_pressure,
	output logic signed [baro_pkg::TEMP_OUT_W-1:0]  temperature_centideg,
	output logic signed [baro_pkg::PRESS_W-1:0]     pressure_pa,
	output logic signed [baro_pkg::TEMP_OUT_W-1:0]  avg_temperature_centideg
);
	import baro_pkg::*;

	localparam int DT_W   = RAW_W + 1;
	localparam int OP_W   = 26;
	localparam int PROD_W = 2 * OP_W;
	localparam int SENS_W = 38;
	localparam int OFF_W  = 38;
	localparam int HALF_W = SENS_W / 2;
	localparam int PART_W = RAW_W + HALF_W;
	localparam int FULL_W = PART_W + HALF_W;
	localparam int DS_W   = FULL_W - 21;
	localparam int NUM_W  = DS_W + 1;
	localparam int QUO_W  = NUM_W - 15;
	localparam int A_W    = 35;
	localparam int A5_W   = A_W + 2;
	localparam int Q_W    = 18;

	localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;

	// Ring geometry and the reciprocal used for the mean.
	localparam int POS_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int SUM_W   = TEMP_W + $clog2(AVG_DEPTH);
	localparam int RECIP_K = SUM_W + $clog2(AVG_DEPTH);
	localparam int RECIP_W = RECIP_K + 1;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];
	localparam int MPROD_W = SUM_W + RECIP_W;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_DEPTH - 1);

	logic [CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	logic        [RAW_W-1:0]   d1_q;
	logic signed [DT_W-1:0]    dt_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic                      cold_q;
	logic signed [OFF_W-1:0]   off_q;
	logic signed [SENS_W-1:0]  sens_q;
	logic        [A5_W-1:0]    a5_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic        [PART_W-1:0]  plo_q;
	logic signed [DS_W-1:0]    ds_q;
	logic signed [NUM_W-1:0]   num_q;
	logic signed [QUO_W-1:0]   quo_q;

	logic signed [TEMP_W-1:0]  ring_mem [AVG_DEPTH];
	logic signed [TEMP_W-1:0]  ring_rd_q;
	logic [AVG_DEPTH-1:0]      ring_vld_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [SUM_W-1:0]   ring_sum_q;
	logic [SUM_W-1:0]          mag_q;
	logic                      neg_q;
	logic [MPROD_W-1:0]        mprod_q;

	logic signed [TEMP_OUT_W-1:0] temp_out_q;
	logic signed [PRESS_W-1:0]    press_out_q;
	logic signed [TEMP_OUT_W-1:0] avg_out_q;

	logic signed [DT_W-1:0]    dt_new;
	logic signed [OP_W-1:0]    op_a;
	logic signed [OP_W-1:0]    op_b;
	logic signed [TEMP_W-1:0]  diff;
	logic [Q_W+23-1:0]         tq_sum;
	logic signed [Q_W-1:0]     tq;
	logic [FULL_W-1:0]         full_sum;
	logic [NUM_W-1:0]          num_biased;
	logic signed [TEMP_W-1:0]  ring_old;
	logic [TEMP_W-1:0]         avg_mag;
	logic signed [TEMP_OUT_W-1:0] avg_signed;

	assign dt_new = $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_q, 8'b0});
	assign diff   = temp_q - TEMP_REF;

	always_comb begin
		op_a = {{(OP_W-DT_W){dt_q[DT_W-1]}}, dt_q};
		op_b = {{(OP_W-CAL_W){1'b0}}, c6_q};
		unique case (cmd.mul_op)
			MUL_DT_C6: begin
				op_a = {{(OP_W-DT_W){dt_q[DT_W-1]}}, dt_q};
				op_b = {{(OP_W-CAL_W){1'b0}}, c6_q};
			end
			MUL_C4_DT: begin
				op_a = {{(OP_W-DT_W){dt_q[DT_W-1]}}, dt_q};
				op_b = {{(OP_W-CAL_W){1'b0}}, c4_q};
			end
			MUL_C3_DT: begin
				op_a = {{(OP_W-DT_W){dt_q[DT_W-1]}}, dt_q};
				op_b = {{(OP_W-CAL_W){1'b0}}, c3_q};
			end
			MUL_DT_DT: begin
				op_a = {{(OP_W-DT_W){dt_q[DT_W-1]}}, dt_q};
				op_b = {{(OP_W-DT_W){dt_q[DT_W-1]}}, dt_q};
			end
			MUL_DIFF_SQ: begin
				op_a = {{(OP_W-TEMP_W){diff[TEMP_W-1]}}, diff};
				op_b = {{(OP_W-TEMP_W){diff[TEMP_W-1]}}, diff};
			end
			MUL_D1_SLO: begin
				op_a = {{(OP_W-RAW_W){1'b0}}, d1_q};
				op_b = {{(OP_W-HALF_W){1'b0}}, sens_q[HALF_W-1:0]};
			end
			MUL_D1_SHI: begin
				op_a = {{(OP_W-RAW_W){1'b0}}, d1_q};
				op_b = {{(OP_W-HALF_W){sens_q[SENS_W-1]}}, sens_q[SENS_W-1:HALF_W]};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Truncation toward zero of dT*C6 / 2^23: bias negative products before the shift.
	assign tq_sum = prod_q[Q_W+23-1:0]
		+ {{Q_W{1'b0}}, {23{prod_q[Q_W+23-1]}}};
	assign tq     = $signed(tq_sum[Q_W+23-1:23]);

	// D1*SENS rebuilt from its two halves.
	assign full_sum = {prod_q[PART_W-1:0], {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, plo_q};

	assign num_biased = num_q + {{(NUM_W-15){1'b0}}, {15{num_q[NUM_W-1]}}};

	assign ring_old = ring_vld_q[pos_q] ? ring_rd_q : '0;

	assign avg_mag    = TEMP_W'(mprod_q >> RECIP_K);
	assign avg_signed = neg_q ? -$signed({1'b0, avg_mag}) : $signed({1'b0, avg_mag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_C1:  c1_q <= cfg_data;
				REG_C2:  c2_q <= cfg_data;
				REG_C3:  c3_q <= cfg_data;
				REG_C4:  c4_q <= cfg_data;
				REG_C5:  c5_q <= cfg_data;
				REG_C6:  c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		case (cmd.step)
			DP_LOAD: begin
				d1_q <= raw_pressure;
				dt_q <= dt_new;
			end
			DP_TEMP: begin
				temp_q <= TEMP_REF + TEMP_W'(tq);
				cold_q <= tq[Q_W-1];
			end
			DP_OFF: begin
				off_q <= $signed({6'b0, c2_q, 16'b0})
					+ $signed({{4{prod_q[40]}}, prod_q[40:7]});
			end
			DP_SENS: begin
				sens_q <= $signed({7'b0, c1_q, 15'b0})
					+ $signed({{5{prod_q[40]}}, prod_q[40:8]});
			end
			DP_T2: begin
				if (cold_q) temp_q <= temp_q - $signed(prod_q[49:31]);
			end
			DP_A5: begin
				a5_q <= {prod_q[A_W-1:0], 2'b00} + {2'b00, prod_q[A_W-1:0]};
			end
			DP_ADJ: begin
				if (cold_q) begin
					off_q  <= off_q - $signed({2'b0, a5_q[A5_W-1:1]});
					sens_q <= sens_q - $signed({3'b0, a5_q[A5_W-1:2]});
				end
			end
			DP_PLO:  plo_q <= prod_q[PART_W-1:0];
			DP_FULL: ds_q <= $signed(full_sum[FULL_W-1:21]);
			DP_DIFF: num_q <= {ds_q[DS_W-1], ds_q} - {{(NUM_W-OFF_W){off_q[OFF_W-1]}}, off_q};
			DP_DIV:  quo_q <= $signed(num_biased[NUM_W-1:15]);
			DP_OUT: begin
				temp_out_q  <= TEMP_OUT_W'(temp_q);
				// The quotient always lies well inside the 32-bit range.
				press_out_q <= PRESS_W'(quo_q);
				avg_out_q   <= avg_signed;
			end
			default: ;
		endcase
		if (cmd.mean_abs) begin
			neg_q <= ring_sum_q[SUM_W-1];
			mag_q <= ring_sum_q[SUM_W-1] ? SUM_W'(-ring_sum_q) : SUM_W'(ring_sum_q);
		end
		if (cmd.mean_mul) mprod_q <= MPROD_W'(mag_q) * MPROD_W'(RECIP_M);
	end

	always_ff @(posedge clk) begin
		ring_rd_q <= ring_mem[pos_q];
		if (cmd.step == DP_ADJ) ring_mem[pos_q] <= temp_q;
	end

	// Entries never written since reset count as zero through the valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			pos_q      <= '0;
			ring_sum_q <= '0;
		end else if (cmd.step == DP_ADJ) begin
			ring_vld_q[pos_q] <= 1'b1;
			ring_sum_q <= ring_sum_q - SUM_W'(ring_old) + SUM_W'(temp_q);
			pos_q      <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
		end
	end

	assign temperature_centideg     = temp_out_q;
	assign pressure_pa              = press_out_q;
	assign avg_temperature_centideg = avg_out_q;

endmodule
